[design/usd_pkg.sv]
// usd_pkg: shared types and constants of the ultrasonic steering decider
// no dependencies; used by usd_lane, usd_merge and ultrasonic_steering_decider
package usd_pkg;

    // configuration register width and register indexes
    localparam int CFG_BITS = 16;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_STOP       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRONT_NEAR = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIDE_OPEN  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_JUMP       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DRIFT      = 3'd4;

    localparam logic [CFG_BITS-1:0] RST_STOP       = 16'd580;
    localparam logic [CFG_BITS-1:0] RST_FRONT_NEAR = 16'd5800;
    localparam logic [CFG_BITS-1:0] RST_SIDE_OPEN  = 16'd11600;
    localparam logic [CFG_BITS-1:0] RST_JUMP       = 16'd290;
    localparam logic [CFG_BITS-1:0] RST_DRIFT      = 16'd116;

    // command codes and hold times
    localparam int CMD_BITS  = 3;
    localparam int HOLD_BITS = 12;

    typedef logic [CMD_BITS-1:0]  cmd_t;
    typedef logic [HOLD_BITS-1:0] hold_t;

    localparam cmd_t CMD_FORWARD     = 3'd1;
    localparam cmd_t CMD_RIGHT       = 3'd2;
    localparam cmd_t CMD_LEFT        = 3'd3;
    localparam cmd_t CMD_VEER_TOWARD = 3'd4;
    localparam cmd_t CMD_VEER_AWAY   = 3'd5;
    localparam cmd_t CMD_STOP        = 3'd6;

    localparam hold_t HOLD_NONE = 12'd0;
    localparam hold_t HOLD_VEER = 12'd200;
    localparam hold_t HOLD_TURN = 12'd2000;
    localparam hold_t HOLD_BACK = 12'd4000;

    // command run buffer
    localparam int RUN_MAX = 5;
    localparam int RUN_IDX_BITS = 3;

    typedef logic [RUN_IDX_BITS-1:0] run_idx_t;

    typedef struct packed {
        cmd_t  cmd;
        hold_t hold;
    } run_entry_t;

    // configuration register set
    typedef struct packed {
        logic [CFG_BITS-1:0] stop_ticks;
        logic [CFG_BITS-1:0] front_near_ticks;
        logic [CFG_BITS-1:0] side_open_ticks;
        logic [CFG_BITS-1:0] jump_ticks;
        logic [CFG_BITS-1:0] drift_ticks;
    } cfg_regs_t;

    // what one sensor lane found for a round
    typedef struct packed {
        logic jump_bad;
        logic below_stop;
        logic below_near;
        logic above_open;
        logic drift_away;
        logic drift_toward;
    } lane_flags_t;

endpackage

[design/usd_lane.sv]
// usd_lane: one sensor lane, two-entry width history and threshold checks
// depends on usd_pkg
module usd_lane
    import usd_pkg::*;
#(
    parameter int W = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load_en,
    input  logic        shift_en,
    input  logic [W-1:0] echo,
    input  cfg_regs_t   cfg,
    output lane_flags_t flags
);

    localparam int CW = ((W > CFG_BITS) ? W : CFG_BITS) + 2;

    logic [W-1:0]         hist_old_reg;
    logic [W-1:0]         hist_new_reg;
    lane_flags_t          flags_reg;
    lane_flags_t          flags_next;
    logic signed [CW-1:0] d1;
    logic signed [CW-1:0] d2;
    logic signed [CW-1:0] jmp;
    logic signed [CW-1:0] drf;
    logic [CW-1:0]        cur_w;

    // differences against history and threshold compares
    always_comb
    begin
        d1    = signed'(CW'(hist_old_reg)) - signed'(CW'(hist_new_reg));
        d2    = signed'(CW'(hist_new_reg)) - signed'(CW'(echo));
        jmp   = signed'(CW'(cfg.jump_ticks));
        drf   = signed'(CW'(cfg.drift_ticks));
        cur_w = CW'(echo);

        flags_next.jump_bad     = (d1 > jmp) || (d1 < -jmp) || (d2 > jmp) || (d2 < -jmp);
        flags_next.below_stop   = cur_w < CW'(cfg.stop_ticks);
        flags_next.below_near   = cur_w < CW'(cfg.front_near_ticks);
        flags_next.above_open   = cur_w > CW'(cfg.side_open_ticks);
        flags_next.drift_away   = (d1 > drf) && (d2 > drf);
        flags_next.drift_toward = (d1 < -drf) && (d2 < -drf);
    end

    // history shift on a usable round
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_old_reg <= '0;
            hist_new_reg <= '0;
        end
        else if (shift_en)
        begin
            hist_old_reg <= hist_new_reg;
            hist_new_reg <= echo;
        end
    end

    // lane result register
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

[design/usd_merge.sv]
// usd_merge: combines the three lane results into a command run and plays it out
// depends on usd_pkg
module usd_merge
    import usd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        round_accept,
    input  logic        round_ok,
    input  lane_flags_t right_flags,
    input  lane_flags_t front_flags,
    input  lane_flags_t left_flags,
    output logic        busy,
    output logic        out_valid,
    input  logic        out_stall,
    output cmd_t        out_cmd,
    output hold_t       out_hold,
    output logic        out_last
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       s1_ok_reg;
    logic       s1_move;
    logic       out_fire;

    run_entry_t run_reg [RUN_MAX];
    run_idx_t   run_cnt_reg;
    run_idx_t   run_idx_reg;
    logic       run_valid_reg;

    run_entry_t build [RUN_MAX];
    run_idx_t   build_cnt;

    // build the run from the lane results
    always_comb
    begin
        build_cnt = '0;
        for (int i = 0; i < RUN_MAX; i++)
        begin
            build[i] = '{cmd: CMD_FORWARD, hold: HOLD_NONE};
        end

        if (right_flags.below_stop || front_flags.below_stop || left_flags.below_stop)
        begin
            build[build_cnt] = '{cmd: CMD_STOP, hold: HOLD_NONE};
            build_cnt = build_cnt + 3'd1;
        end

        if (right_flags.above_open)
        begin
            build[build_cnt] = '{cmd: CMD_RIGHT, hold: HOLD_TURN};
            build[build_cnt + 3'd1] = '{cmd: CMD_FORWARD, hold: HOLD_TURN};
            build_cnt = build_cnt + 3'd2;
        end
        else if (front_flags.below_near)
        begin
            if (left_flags.above_open)
            begin
                build[build_cnt] = '{cmd: CMD_LEFT, hold: HOLD_TURN};
                build[build_cnt + 3'd1] = '{cmd: CMD_FORWARD, hold: HOLD_TURN};
            end
            else
            begin
                build[build_cnt] = '{cmd: CMD_RIGHT, hold: HOLD_BACK};
                build[build_cnt + 3'd1] = '{cmd: CMD_FORWARD, hold: HOLD_NONE};
            end
            build_cnt = build_cnt + 3'd2;
        end

        if (right_flags.drift_away)
        begin
            build[build_cnt] = '{cmd: CMD_VEER_AWAY, hold: HOLD_VEER};
            build[build_cnt + 3'd1] = '{cmd: CMD_FORWARD, hold: HOLD_NONE};
            build_cnt = build_cnt + 3'd2;
        end
        else if (right_flags.drift_toward)
        begin
            build[build_cnt] = '{cmd: CMD_VEER_TOWARD, hold: HOLD_VEER};
            build[build_cnt + 3'd1] = '{cmd: CMD_FORWARD, hold: HOLD_NONE};
            build_cnt = build_cnt + 3'd2;
        end

        // rejected rounds give an empty run
        if (!s1_ok_reg || right_flags.jump_bad || front_flags.jump_bad || left_flags.jump_bad)
        begin
            build_cnt = '0;
        end
    end

    // handshake between lane stage and run buffer
    assign out_valid = run_valid_reg;
    assign out_last  = run_idx_reg == (run_cnt_reg - 3'd1);
    assign out_fire  = run_valid_reg && !out_stall;
    assign s1_move   = s1_valid_reg && (!run_valid_reg || (out_fire && out_last));
    assign busy      = s1_valid_reg && !s1_move;
    assign out_cmd   = run_reg[run_idx_reg].cmd;
    assign out_hold  = run_reg[run_idx_reg].hold;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (round_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // lane stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (round_accept)
        begin
            s1_ok_reg <= round_ok;
        end
    end

    // run buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            run_cnt_reg   <= '0;
            run_idx_reg   <= '0;
        end
        else if (s1_move)
        begin
            run_valid_reg <= build_cnt != '0;
            run_cnt_reg   <= build_cnt;
            run_idx_reg   <= '0;
        end
        else if (out_fire)
        begin
            if (out_last)
            begin
                run_valid_reg <= 1'b0;
            end
            else
            begin
                run_idx_reg <= run_idx_reg + 3'd1;
            end
        end
    end

    // run buffer words
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            for (int i = 0; i < RUN_MAX; i++)
            begin
                run_reg[i] <= build[i];
            end
        end
    end

    // checks
    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |-> (run_cnt_reg != '0) && (run_idx_reg < run_cnt_reg)
                          && (run_cnt_reg <= 3'(RUN_MAX)))
        else $error("run index outside run");

    a_stop_leads: assert property (@(posedge clk) disable iff (!rst_n)
        (run_valid_reg && run_idx_reg != '0) |-> out_cmd != CMD_STOP)
        else $error("stop command not at head of run");

    a_last_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (run_valid_reg && out_last) |-> (out_cmd == CMD_FORWARD || out_cmd == CMD_STOP))
        else $error("run ends on a turn or veer");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (run_valid_reg && out_stall) |=> run_valid_reg && $stable(run_idx_reg))
        else $error("run position moved under stall");

endmodule

[design/ultrasonic_steering_decider.sv]
// ultrasonic_steering_decider: top level, config registers, three sensor lanes, merge
// depends on usd_pkg, usd_lane, usd_merge
//
//   channel  | handshake              | word
//   ---------+------------------------+------------------------------------------
//   round    | round_valid/round_stall| echo_right, echo_front, echo_left, timed_out
//   cmd      | cmd_valid/cmd_stall    | command, hold_ms, last
//   cfg      | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// a round enters the lane stage at its accepting edge and its run is loaded once the run
// buffer is free; the buffer then offers one word per cycle while cmd_stall is low
// rounds without commands are taken every cycle while no run is held; behind a run of n
// words (n up to 5) the next round waits in the lane stage until that run's last word is taken
// reset clears the histories and valids and sets the config registers to their defaults
// round_stall: lane stage full and its run blocked; cmd_stall holds the current word
module ultrasonic_steering_decider
    import usd_pkg::*;
#(
    parameter int TICK_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    round_valid,
    output logic                    round_stall,
    input  logic [TICK_BITS-1:0]    echo_right,
    input  logic [TICK_BITS-1:0]    echo_front,
    input  logic [TICK_BITS-1:0]    echo_left,
    input  logic                    timed_out,
    output logic                    cmd_valid,
    input  logic                    cmd_stall,
    output logic [CMD_BITS-1:0]     command,
    output logic [HOLD_BITS-1:0]    hold_ms,
    output logic                    last,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data
);

    cfg_regs_t   cfg_reg;
    cfg_regs_t   cfg_next;
    logic        round_accept;
    logic        round_ok;
    logic        merge_busy;
    lane_flags_t right_flags;
    lane_flags_t front_flags;
    lane_flags_t left_flags;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_STOP:       cfg_next.stop_ticks       = cfg_data;
                REG_FRONT_NEAR: cfg_next.front_near_ticks = cfg_data;
                REG_SIDE_OPEN:  cfg_next.side_open_ticks  = cfg_data;
                REG_JUMP:       cfg_next.jump_ticks       = cfg_data;
                REG_DRIFT:      cfg_next.drift_ticks      = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{stop_ticks:       RST_STOP,
                         front_near_ticks: RST_FRONT_NEAR,
                         side_open_ticks:  RST_SIDE_OPEN,
                         jump_ticks:       RST_JUMP,
                         drift_ticks:      RST_DRIFT};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // round acceptance; timeouts and zero widths leave the histories alone
    assign round_stall  = merge_busy;
    assign round_accept = round_valid && !round_stall;
    assign round_ok     = !timed_out && (echo_right != '0) && (echo_front != '0)
                          && (echo_left != '0);

    // sensor lanes
    usd_lane #(.W(TICK_BITS)) u_lane_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .load_en  (round_accept),
        .shift_en (round_accept && round_ok),
        .echo     (echo_right),
        .cfg      (cfg_reg),
        .flags    (right_flags)
    );

    usd_lane #(.W(TICK_BITS)) u_lane_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .load_en  (round_accept),
        .shift_en (round_accept && round_ok),
        .echo     (echo_front),
        .cfg      (cfg_reg),
        .flags    (front_flags)
    );

    usd_lane #(.W(TICK_BITS)) u_lane_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .load_en  (round_accept),
        .shift_en (round_accept && round_ok),
        .echo     (echo_left),
        .cfg      (cfg_reg),
        .flags    (left_flags)
    );

    // merge and command playout
    usd_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .round_accept (round_accept),
        .round_ok     (round_ok),
        .right_flags  (right_flags),
        .front_flags  (front_flags),
        .left_flags   (left_flags),
        .busy         (merge_busy),
        .out_valid    (cmd_valid),
        .out_stall    (cmd_stall),
        .out_cmd      (command),
        .out_hold     (hold_ms),
        .out_last     (last)
    );

endmodule
